// ----- hw/rtl/ffca_pkg.sv -----
package ffca_pkg;

	localparam int ID_W    = 16;
	localparam int CNT_W   = 8;
	localparam int START_W = 7;
	localparam int ST_W    = 2;
	localparam int CFG_W   = 8;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_NOSPACE  = 2'd1;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

	// Control of the run counter.
	typedef struct packed {
		logic clr;
		logic step;
		logic free_bit;
	} ffca_run_ctl_t;

endpackage

// ----- hw/rtl/ffca_if.sv -----
interface ffca_req_if import ffca_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic [ID_W-1:0]  file_id;
	logic [CNT_W-1:0] block_count;

	modport source(output valid, output kind, output file_id, output block_count,
		input ready);
	modport sink(input valid, input kind, input file_id, input block_count,
		output ready);
endinterface

interface ffca_rsp_if import ffca_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ST_W-1:0]    status;
	logic [START_W-1:0] start_block;
	logic [CNT_W-1:0]   run_length;

	modport source(output valid, output status, output start_block, output run_length,
		input ready);
	modport sink(input valid, input status, input start_block, input run_length,
		output ready);
endinterface

// ----- hw/rtl/ffca_ram.sv -----
module ffca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/ffca_run_unit.sv -----
module ffca_run_unit import ffca_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ffca_run_ctl_t    ctl,
	input  logic [CNT_W-1:0] len,
	output logic             hit
);

	logic [CNT_W-1:0] run_q;
	logic [CNT_W:0]   run_inc;

	assign run_inc = {1'b0, run_q} + (CNT_W+1)'(1);
	assign hit = ctl.step && ctl.free_bit && (run_inc == {1'b0, len});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (ctl.clr) begin
			run_q <= '0;
		end else if (ctl.step) begin
			run_q <= ctl.free_bit ? run_inc[CNT_W-1:0] : '0;
		end
	end

endmodule

// ----- hw/rtl/first_fit_contiguous_allocator.sv -----
// Channel  Dir  Payload                              Item
// req      in   kind, file_id, block_count           one allocate or free request
// rsp      out  status, start_block, run_length      one result per request
// cfg      in   cfg_we, cfg_wdata (total_blocks)     write of the usable block count
//
// After reset and after every cfg write the free map is swept, one block per cycle,
// marking all NUM_BLOCKS blocks free; req is not ready during the sweep.
// Allocate, unless the directory is full or block_count is zero, scans the usable blocks
// with one free-map read per cycle through the run counter, then one write per marked block.
// Free searches the directory and, on a match, compacts it and marks the freed blocks.
// A stalled rsp holds the block only in its final step; the next req follows the result.
module first_fit_contiguous_allocator import ffca_pkg::*; #(
	parameter int NUM_BLOCKS  = 128,
	parameter int DIR_ENTRIES = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	ffca_req_if.sink         req,
	ffca_rsp_if.source       rsp
);

	localparam int SW = $clog2(NUM_BLOCKS);
	localparam int DI = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
	localparam int TW = $clog2(DIR_ENTRIES + 1);
	localparam int EW = ID_W + SW + CNT_W;
	localparam int WW = (SW + 2 > CFG_W + 1) ? SW + 2 : CFG_W + 1;
	localparam int LIMIT_RST = (NUM_BLOCKS < 128) ? NUM_BLOCKS : 128;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SWEEP  = 3'd1;
	localparam logic [2:0] S_ASCAN  = 3'd2;
	localparam logic [2:0] S_AMARK  = 3'd3;
	localparam logic [2:0] S_FSCAN  = 3'd4;
	localparam logic [2:0] S_FSHIFT = 3'd5;
	localparam logic [2:0] S_FMARK  = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0]       state_q;
	logic [SW:0]      limit_q;
	logic [TW-1:0]    total_q;
	logic [ID_W-1:0]  id_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SW:0]      ra_q;
	logic [TW-1:0]    da_q;
	logic             pv_s1;
	logic [SW:0]      bidx_s1;
	logic [TW-1:0]    didx_s1;
	logic [SW-1:0]    blk_q;
	logic [CNT_W-1:0] rem_q;
	logic [ST_W-1:0]  res_st_q;
	logic [SW-1:0]    res_start_q;
	logic [CNT_W-1:0] res_len_q;

	logic               out_valid_q;
	logic [ST_W-1:0]    out_st_q;
	logic [START_W-1:0] out_start_q;
	logic [CNT_W-1:0]   out_len_q;

	logic          fm_we, fm_wdata, fm_re, fm_rdata;
	logic [SW-1:0] fm_waddr, fm_raddr;
	logic          dir_we, dir_re;
	logic [DI-1:0] dir_waddr, dir_raddr;
	logic [EW-1:0] dir_wdata, dir_rdata;

	ffca_run_ctl_t run_ctl;
	logic          run_hit;

	logic             dir_full, acc, acc_zero, out_free;
	logic [SW-1:0]    hit_start;
	logic [ID_W-1:0]  e_id;
	logic [SW-1:0]    e_start;
	logic [CNT_W-1:0] e_size;
	logic [WW-1:0]    cfg_ext;
	logic [SW:0]      limit_new;

	assign e_id    = dir_rdata[EW-1 -: ID_W];
	assign e_start = dir_rdata[CNT_W +: SW];
	assign e_size  = dir_rdata[CNT_W-1:0];

	assign dir_full  = (total_q == TW'(DIR_ENTRIES));
	assign acc       = req.valid && req.ready;
	assign acc_zero  = acc && (req.kind == KIND_ALLOC) && !dir_full && (req.block_count == '0);
	assign out_free  = !out_valid_q || rsp.ready;
	assign hit_start = SW'(WW'(bidx_s1) + WW'(1) - WW'(cnt_q));

	assign cfg_ext   = WW'(cfg_wdata);
	assign limit_new = (cfg_ext > WW'(NUM_BLOCKS)) ? (SW+1)'(NUM_BLOCKS) : (SW+1)'(cfg_ext);

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_st_q;
	assign rsp.start_block = out_start_q;
	assign rsp.run_length  = out_len_q;

	assign run_ctl.clr      = (state_q != S_ASCAN);
	assign run_ctl.step     = (state_q == S_ASCAN) && pv_s1;
	assign run_ctl.free_bit = fm_rdata;

	always_comb begin
		fm_re    = (state_q == S_ASCAN) && (ra_q < limit_q);
		fm_raddr = ra_q[SW-1:0];
		fm_we    = 1'b0;
		fm_waddr = blk_q;
		fm_wdata = 1'b1;
		case (state_q)
			S_SWEEP: begin
				fm_we = 1'b1;
			end
			S_AMARK: begin
				fm_we    = 1'b1;
				fm_wdata = 1'b0;
			end
			S_FMARK: begin
				fm_we = 1'b1;
			end
			default: begin
				fm_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		dir_re    = ((state_q == S_FSCAN) || (state_q == S_FSHIFT)) && (da_q < total_q);
		dir_raddr = da_q[DI-1:0];
		dir_we    = 1'b0;
		dir_waddr = total_q[DI-1:0];
		dir_wdata = {req.file_id, {SW{1'b0}}, {CNT_W{1'b0}}};
		if (acc_zero) begin
			dir_we = 1'b1;
		end else if (run_hit) begin
			dir_we    = 1'b1;
			dir_wdata = {id_q, hit_start, cnt_q};
		end else if ((state_q == S_FSHIFT) && pv_s1) begin
			// Each later entry moves down one place to close the gap.
			dir_we    = 1'b1;
			dir_waddr = DI'(didx_s1 - TW'(1));
			dir_wdata = dir_rdata;
		end
	end

	ffca_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_free_map (
		.clk   (clk),
		.we    (fm_we),
		.waddr (fm_waddr),
		.wdata (fm_wdata),
		.re    (fm_re),
		.raddr (fm_raddr),
		.rdata (fm_rdata)
	);

	ffca_ram #(.WIDTH(EW), .DEPTH(DIR_ENTRIES)) u_dir (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.re    (dir_re),
		.raddr (dir_raddr),
		.rdata (dir_rdata)
	);

	ffca_run_unit u_run (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (run_ctl),
		.len    (cnt_q),
		.hit    (run_hit)
	);

	always_ff @(posedge clk) begin
		bidx_s1 <= ra_q;
		didx_s1 <= da_q;
		if (acc) begin
			id_q  <= req.file_id;
			cnt_q <= req.block_count;
		end
		if (state_q == S_DONE && out_free) begin
			out_st_q    <= res_st_q;
			out_start_q <= START_W'(res_start_q);
			out_len_q   <= res_len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			limit_q     <= (SW+1)'(LIMIT_RST);
			total_q     <= '0;
			ra_q        <= '0;
			da_q        <= '0;
			pv_s1       <= 1'b0;
			blk_q       <= '0;
			rem_q       <= '0;
			res_st_q    <= ST_OK;
			res_start_q <= '0;
			res_len_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pv_s1 <= fm_re || dir_re;
			if (fm_re) begin
				ra_q <= ra_q + (SW+1)'(1);
			end
			if (dir_re) begin
				da_q <= da_q + TW'(1);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				limit_q <= limit_new;
				blk_q   <= '0;
				state_q <= S_SWEEP;
			end else begin
				case (state_q)
					S_SWEEP: begin
						blk_q <= blk_q + SW'(1);
						if (blk_q == SW'(NUM_BLOCKS - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						res_start_q <= '0;
						res_len_q   <= '0;
						ra_q        <= '0;
						da_q        <= '0;
						if (acc) begin
							if (req.kind == KIND_FREE) begin
								state_q <= S_FSCAN;
							end else if (dir_full) begin
								res_st_q <= ST_FULL;
								state_q  <= S_DONE;
							end else if (acc_zero) begin
								total_q  <= total_q + TW'(1);
								res_st_q <= ST_OK;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_ASCAN;
							end
						end
					end
					S_ASCAN: begin
						if (run_hit) begin
							total_q     <= total_q + TW'(1);
							res_st_q    <= ST_OK;
							res_start_q <= hit_start;
							res_len_q   <= cnt_q;
							blk_q       <= hit_start;
							rem_q       <= cnt_q;
							state_q     <= S_AMARK;
						end else if (!pv_s1 && (ra_q >= limit_q)) begin
							res_st_q <= ST_NOSPACE;
							state_q  <= S_DONE;
						end
					end
					S_AMARK, S_FMARK: begin
						blk_q <= blk_q + SW'(1);
						rem_q <= rem_q - CNT_W'(1);
						if (rem_q == CNT_W'(1)) begin
							state_q <= S_DONE;
						end
					end
					S_FSCAN: begin
						if (pv_s1 && (e_id == id_q)) begin
							res_st_q    <= ST_OK;
							res_start_q <= e_start;
							res_len_q   <= e_size;
							state_q     <= S_FSHIFT;
						end else if (!pv_s1 && (da_q >= total_q)) begin
							res_st_q <= ST_NOTFOUND;
							state_q  <= S_DONE;
						end
					end
					S_FSHIFT: begin
						if (!pv_s1 && (da_q >= total_q)) begin
							total_q <= total_q - TW'(1);
							blk_q   <= res_start_q;
							rem_q   <= res_len_q;
							state_q <= (res_len_q == '0) ? S_DONE : S_FMARK;
						end
					end
					S_DONE: begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

endmodule

// ----- dv/first_fit_contiguous_allocator_tb.sv -----
module first_fit_contiguous_allocator_tb;
	import ffca_pkg::*;

	localparam int NBLK = 128;
	localparam int DIRS = 128;
	localparam int CNT_MAX = 128;
	// Slowest item: a full scan or directory walk plus a full mark,
	// plus a random send gap and receive stall. Some 1800 items and a dozen
	// map sweeps stay far below the limit; the limit leaves a wide margin.
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int DRAIN_CYCLES = 2 * NBLK + 40;
	localparam int N_SCRIPT = 19;
	localparam int N_PHASES = 12;

	typedef struct packed {
		logic [ST_W-1:0]    status;
		logic [START_W-1:0] start;
		logic [CNT_W-1:0]   len;
	} reply_t;

	typedef struct packed {
		logic             kind;
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] count;
		logic             typed;
		reply_t           typed_reply;
	} script_row_t;

	typedef struct packed {
		logic [CFG_W-1:0] setting;
		int unsigned      items;
		int unsigned      alloc_pct;
		bit               tiny;
	} phase_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	ffca_req_if req_ch();
	ffca_rsp_if rsp_ch();

	first_fit_contiguous_allocator #(
		.NUM_BLOCKS(NBLK),
		.DIR_ENTRIES(DIRS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Mirror of the allocator: free map (1 = free) and the compacted directory.
	logic [NBLK-1:0]  free_blocks;
	logic [ID_W-1:0]  dir_ids [DIRS];
	int               dir_starts [DIRS];
	int               dir_sizes [DIRS];
	int               dir_used;
	int               blocks_setting;

	reply_t           owed_replies [$];
	int unsigned      mismatches;
	int unsigned      cycle_count;
	bit               idle_on;

	// Hand-checked rows come right after reset with all 128 blocks usable.
	script_row_t alloc_script [N_SCRIPT] = '{
		'{KIND_ALLOC, 16'h0000, 8'd0,   1'b1, '{ST_OK, 7'd0, 8'd0}},
		'{KIND_ALLOC, 16'hFFFF, 8'd128, 1'b1, '{ST_OK, 7'd0, 8'd128}},
		'{KIND_ALLOC, 16'h1234, 8'd1,   1'b1, '{ST_NOSPACE, 7'd0, 8'd0}},
		'{KIND_ALLOC, 16'h1234, 8'd0,   1'b1, '{ST_OK, 7'd0, 8'd0}},
		'{KIND_FREE,  16'hABCD, 8'd0,   1'b1, '{ST_NOTFOUND, 7'd0, 8'd0}},
		'{KIND_FREE,  16'hFFFF, 8'd128, 1'b1, '{ST_OK, 7'd0, 8'd128}},
		'{KIND_ALLOC, 16'h0001, 8'd5,   1'b1, '{ST_OK, 7'd0, 8'd5}},
		'{KIND_ALLOC, 16'h0001, 8'd3,   1'b0, '0},
		'{KIND_ALLOC, 16'h0002, 8'd4,   1'b0, '0},
		'{KIND_FREE,  16'h0001, 8'd0,   1'b1, '{ST_OK, 7'd0, 8'd5}},
		'{KIND_ALLOC, 16'h0003, 8'd2,   1'b0, '0},
		'{KIND_ALLOC, 16'h0004, 8'd4,   1'b0, '0},
		'{KIND_ALLOC, 16'h0005, 8'd3,   1'b0, '0},
		'{KIND_FREE,  16'h0001, 8'd77,  1'b0, '0},
		'{KIND_FREE,  16'h0001, 8'd0,   1'b1, '{ST_NOTFOUND, 7'd0, 8'd0}},
		'{KIND_ALLOC, 16'h7FFF, 8'd127, 1'b0, '0},
		'{KIND_FREE,  16'h0000, 8'd0,   1'b1, '{ST_OK, 7'd0, 8'd0}},
		'{KIND_FREE,  16'h1234, 8'd128, 1'b0, '0},
		'{KIND_FREE,  16'h0002, 8'd255, 1'b0, '0}
	};

	// The tiny phase mostly makes zero- and one-block files so the directory fills up.
	phase_t phase_plan [N_PHASES] = '{
		'{8'd128, 150, 60, 1'b0},
		'{8'd37,  150, 55, 1'b0},
		'{8'd0,   100, 50, 1'b0},
		'{8'd255, 150, 60, 1'b0},
		'{8'd1,   100, 50, 1'b0},
		'{8'd128, 240, 95, 1'b1},
		'{8'd128, 150, 45, 1'b0},
		'{8'd2,   100, 55, 1'b0},
		'{8'd64,  160, 60, 1'b0},
		'{8'd129, 150, 55, 1'b0},
		'{8'd100, 150, 55, 1'b0},
		'{8'd128, 150, 55, 1'b0}
	};

	function automatic reply_t apply_file_request(input logic kind, input logic [ID_W-1:0] id,
		input logic [CNT_W-1:0] count);
		reply_t r;
		int limit;
		int run;
		int hit;
		int b;
		int i;
		r = '0;
		r.status = ST_OK;
		hit = -1;
		if (kind == KIND_ALLOC) begin
			if (dir_used >= DIRS) begin
				r.status = ST_FULL;
				return r;
			end
			limit = (blocks_setting > NBLK) ? NBLK : blocks_setting;
			if (count == 0) begin
				hit = 0;
			end else begin
				run = 0;
				for (b = 0; b < limit && hit < 0; b++) begin
					run = free_blocks[b] ? run + 1 : 0;
					if (run == int'(count))
						hit = b + 1 - int'(count);
				end
			end
			if (hit < 0) begin
				r.status = ST_NOSPACE;
				return r;
			end
			for (b = hit; b < hit + int'(count); b++)
				free_blocks[b] = 1'b0;
			dir_ids[dir_used] = id;
			dir_starts[dir_used] = hit;
			dir_sizes[dir_used] = int'(count);
			dir_used++;
			r.start = START_W'(hit);
			r.len = count;
		end else begin
			for (i = 0; i < dir_used && hit < 0; i++) begin
				if (dir_ids[i] == id)
					hit = i;
			end
			if (hit < 0) begin
				r.status = ST_NOTFOUND;
				return r;
			end
			r.start = START_W'(dir_starts[hit]);
			r.len = CNT_W'(dir_sizes[hit]);
			for (b = dir_starts[hit]; b < dir_starts[hit] + dir_sizes[hit]; b++) begin
				if (b < NBLK)
					free_blocks[b] = 1'b1;
			end
			for (i = hit; i + 1 < dir_used; i++) begin
				dir_ids[i] = dir_ids[i + 1];
				dir_starts[i] = dir_starts[i + 1];
				dir_sizes[i] = dir_sizes[i + 1];
			end
			dir_used--;
		end
		return r;
	endfunction

	function automatic void note_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH %s: expected %0d, got %0d", what, want, got);
	endfunction

	task automatic send_request(input logic kind, input logic [ID_W-1:0] id,
		input logic [CNT_W-1:0] count, input logic typed, input reply_t typed_reply);
		int gap;
		reply_t predicted;
		gap = idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.file_id <= id;
		req_ch.block_count <= count;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predicted = apply_file_request(kind, id, count);
		owed_replies.push_back(typed ? typed_reply : predicted);
	endtask

	// Register writes only happen once every reply is back and the block is idle.
	task automatic write_block_count(input logic [CFG_W-1:0] setting);
		req_ch.valid <= 1'b0;
		while (owed_replies.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= setting;
		@(posedge clk);
		cfg_we <= 1'b0;
		blocks_setting = int'(setting);
		free_blocks = '1;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : reply_check
		int stall;
		reply_t got;
		reply_t want;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = idle_on ? $urandom_range(0, 9) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			got.status = rsp_ch.status;
			got.start = rsp_ch.start_block;
			got.len = rsp_ch.run_length;
			if (owed_replies.size() == 0) begin
				note_mismatch("reply with nothing pending, status", -1, int'(got.status));
			end else begin
				want = owed_replies.pop_front();
				if (got.status !== want.status)
					note_mismatch("status", int'(want.status), int'(got.status));
				if (got.start !== want.start)
					note_mismatch("start_block", int'(want.start), int'(got.start));
				if (got.len !== want.len)
					note_mismatch("run_length", int'(want.len), int'(got.len));
			end
		end
	end

	initial begin : stimulus
		int unsigned p;
		int unsigned n;
		int unsigned pick;
		logic kind;
		logic [ID_W-1:0] id;
		logic [CNT_W-1:0] count;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_ALLOC;
		req_ch.file_id <= '0;
		req_ch.block_count <= '0;
		mismatches = 0;
		idle_on = 1'b1;
		free_blocks = '1;
		dir_used = 0;
		blocks_setting = 128;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < N_SCRIPT; n++)
			send_request(alloc_script[n].kind, alloc_script[n].id, alloc_script[n].count,
				alloc_script[n].typed, alloc_script[n].typed_reply);

		for (p = 0; p < N_PHASES; p++) begin
			write_block_count(phase_plan[p].setting);
			for (n = 0; n < phase_plan[p].items; n++) begin
				if ($urandom_range(0, 49) == 0)
					idle_on = ~idle_on;
				if ($urandom_range(1, 100) <= phase_plan[p].alloc_pct) begin
					kind = KIND_ALLOC;
					// Some new files reuse a live id so duplicates stay in the directory.
					if (dir_used > 0 && $urandom_range(0, 3) == 0)
						id = dir_ids[$urandom_range(0, dir_used - 1)];
					else
						id = ID_W'($urandom);
					if (phase_plan[p].tiny) begin
						count = CNT_W'($urandom_range(0, 1));
					end else begin
						pick = $urandom_range(0, 99);
						if (pick < 8)
							count = '0;
						else if (pick < 80)
							count = CNT_W'($urandom_range(1, 8));
						else if (pick < 95)
							count = CNT_W'($urandom_range(9, 32));
						else
							count = CNT_W'($urandom_range(33, CNT_MAX));
					end
				end else begin
					kind = KIND_FREE;
					if (dir_used > 0 && $urandom_range(0, 6) != 0)
						id = dir_ids[$urandom_range(0, dir_used - 1)];
					else
						id = ID_W'($urandom);
					count = CNT_W'($urandom_range(0, CNT_MAX));
				end
				send_request(kind, id, count, 1'b0, '0);
			end
		end

		req_ch.valid <= 1'b0;
		while (owed_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
